>>> rtl/barometric_pressure_compensation_defines.svh
// assertion macros for the pressure compensation block
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_DEFINES_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_DEFINES_SVH
`define BPC_ASSERT_IMP(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("check failed");
`define BPC_ASSERT_NXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("check failed");
`endif

>>> rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// types, constants, register indices and state codes of the pressure compensation block
// ----------------------------------------------------------------------------
package bpc_pkg;
  localparam int unsigned WordW = 32;
  localparam logic [31:0] TempOffset = 32'd4000;
  localparam logic [31:0] KP1 = 32'd3038;
  localparam logic [31:0] KP2 = 32'hFFFF_E343; // -7357
  localparam logic [31:0] KP3 = 32'd3791;
  localparam logic [31:0] KB7 = 32'd50000;
  localparam logic [31:0] KHalf = 32'd32768;

  typedef enum logic [1:0] {
    REG_MODE = 2'd0,
    REG_GRP_A = 2'd1,
    REG_GRP_B = 2'd2,
    REG_GRP_C = 2'd3
  } reg_idx_t;

  typedef enum logic [5:0] {
    S_IDLE, S_T0, S_T1, S_T2, S_TDIV, S_TEND,
    S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
    S_PDIV, S_PQ, S_P10, S_P11, S_P12, S_P13, S_DONE
  } state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

  function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
    asr = 32'($signed(v) >>> s);
  endfunction
endpackage

>>> rtl/bpc_if.sv
// ----------------------------------------------------------------------------
// bpc_in_if / bpc_out_if
// valid-ready channels of the block
// ----------------------------------------------------------------------------
interface bpc_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [23:0] raw_sample;
  modport source (output valid, operation, raw_sample, input ready);
  modport sink (input valid, operation, raw_sample, output ready);
endinterface

interface bpc_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] measurement;
  logic               status;
  modport source (output valid, kind, measurement, status, input ready);
  modport sink (input valid, kind, measurement, status, output ready);
endinterface

>>> rtl/bpc_div.sv
// ----------------------------------------------------------------------------
// bpc_div
// unsigned 32-bit restoring divider, one quotient bit a cycle
// ----------------------------------------------------------------------------
module bpc_div import bpc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic [31:0] rem_r, rem_nxt, quo_r, quo_nxt, dvs_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [32:0] trial;

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r, quo_r[31]} - {1'b0, dvs_r};
    if (req.start) begin
      rem_nxt = '0;
      quo_nxt = req.dividend;
      cnt_nxt = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
      end else begin
        rem_nxt = {rem_r[30:0], quo_r[31]};
      end
      quo_nxt = {quo_r[30:0], ~trial[32]};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (req.start) begin
      dvs_r <= req.divisor;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quotient = quo_r;
endmodule

>>> rtl/barometric_pressure_compensation.sv
// ----------------------------------------------------------------------------
// barometric_pressure_compensation
// temperature and pressure compensation on one shared multiplier and divider
// ----------------------------------------------------------------------------
// channel  dir  payload
// in       in   operation, raw_sample
// out      out  kind, measurement, status
// cfg      in   cfg_we, cfg_index, cfg_data
// a temperature item runs S_T0 to S_T2, the divider and S_TEND, a pressure item S_P0 to
// S_P9, the divider, S_PQ and S_P10 to S_P12; a zero divisor ends it at S_T2 or S_P9
// the 32-step divider is the longest part of an item, at most one multiply per step
// in_ready is high only while idle with the output register empty
// a stalled result holds the block until it is taken
// reset is synchronous, active low; no clearing pass
module barometric_pressure_compensation import bpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  bpc_in_if.sink      in_ch,
  bpc_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
`include "barometric_pressure_compensation_defines.svh"
  state_t state_r, state_nxt;
  logic [1:0]  mode_r;
  logic [63:0] ga_r, gb_r;
  logic [31:0] gc_r;
  logic [31:0] b5_r, b5_nxt;
  logic        op_r;
  logic [23:0] raw_r;
  logic [31:0] a_r, a_nxt, b_r, b_nxt, c_r, c_nxt, d_r, d_nxt, e_r, e_nxt, f_r, f_nxt;
  logic        neg_r, neg_nxt;
  logic [31:0] ma, mb, mp;
  logic        ovalid_r, ovalid_nxt, ostat_r, ostat_nxt;
  logic [31:0] omeas_r, omeas_nxt;
  div_req_t    dreq;
  div_rsp_t    drsp;

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = {{16{ga_r[63]}}, ga_r[63:48]};
  assign ac2 = {{16{ga_r[47]}}, ga_r[47:32]};
  assign ac3 = {{16{ga_r[31]}}, ga_r[31:16]};
  assign ac4 = {16'd0, ga_r[15:0]};
  assign ac5 = {16'd0, gb_r[63:48]};
  assign ac6 = {16'd0, gb_r[47:32]};
  assign b1 = {{16{gb_r[31]}}, gb_r[31:16]};
  assign b2 = {{16{gb_r[15]}}, gb_r[15:0]};
  assign mc = {{16{gc_r[31]}}, gc_r[31:16]};
  assign md = {{16{gc_r[15]}}, gc_r[15:0]};

  assign mp = 32'(ma * mb);

  bpc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign in_ch.ready = (state_r == S_IDLE) && !ovalid_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.kind = op_r;
  assign out_ch.measurement = omeas_r;
  assign out_ch.status = ostat_r;

  always_comb begin
    state_nxt = state_r;
    a_nxt = a_r; b_nxt = b_r; c_nxt = c_r; d_nxt = d_r; e_nxt = e_r; f_nxt = f_r;
    neg_nxt = neg_r;
    b5_nxt = b5_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    ostat_nxt = ostat_r;
    omeas_nxt = omeas_r;
    ma = '0;
    mb = '0;
    dreq = '0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          state_nxt = in_ch.operation ? S_P0 : S_T0;
        end
      end
      // x1 = ((ut-ac6)*ac5)>>15
      S_T0: begin
        ma = {16'd0, raw_r[15:0]} - ac6; mb = ac5;
        a_nxt = asr(mp, 5'd15);
        state_nxt = S_T1;
      end
      S_T1: begin
        b_nxt = a_r + md;
        c_nxt = mc << 11;
        state_nxt = S_T2;
      end
      S_T2: begin
        if (b_r == '0) begin
          ostat_nxt = 1'b1; omeas_nxt = '0; ovalid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          neg_nxt = b_r[31] ^ c_r[31];
          dreq.start = 1'b1;
          dreq.dividend = c_r[31] ? -c_r : c_r;
          dreq.divisor = b_r[31] ? -b_r : b_r;
          state_nxt = S_TDIV;
        end
      end
      S_TDIV: begin
        if (drsp.done) begin
          d_nxt = neg_r ? -drsp.quotient : drsp.quotient;
          state_nxt = S_TEND;
        end
      end
      S_TEND: begin
        b5_nxt = a_r + d_r;
        ostat_nxt = 1'b0;
        omeas_nxt = asr(a_r + d_r + 32'd8, 5'd4);
        ovalid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      // pressure: a=b6, b=sq
      S_P0: begin
        a_nxt = b5_r - TempOffset;
        state_nxt = S_P1;
      end
      S_P1: begin
        ma = a_r; mb = a_r; b_nxt = asr(mp, 5'd12);
        state_nxt = S_P2;
      end
      S_P2: begin
        ma = b2; mb = b_r; c_nxt = asr(mp, 5'd11);
        state_nxt = S_P3;
      end
      S_P3: begin
        ma = ac2; mb = a_r; c_nxt = c_r + asr(mp, 5'd11);
        state_nxt = S_P4;
      end
      // c = b3
      S_P4: begin
        c_nxt = asr((((ac1 << 2) + c_r) << mode_r) + 32'd2, 5'd2);
        state_nxt = S_P5;
      end
      S_P5: begin
        ma = ac3; mb = a_r; d_nxt = asr(mp, 5'd13);
        state_nxt = S_P6;
      end
      S_P6: begin
        ma = b1; mb = b_r; d_nxt = asr(d_r + asr(mp, 5'd16) + 32'd2, 5'd2);
        state_nxt = S_P7;
      end
      // e = b4
      S_P7: begin
        ma = ac4; mb = d_r + KHalf; e_nxt = mp >> 15;
        state_nxt = S_P8;
      end
      // f = b7
      S_P8: begin
        ma = ({8'd0, raw_r} >> (4'd8 - {2'd0, mode_r})) - c_r;
        mb = KB7 >> mode_r;
        f_nxt = mp;
        state_nxt = S_P9;
      end
      S_P9: begin
        if (e_r == '0) begin
          ostat_nxt = 1'b1; omeas_nxt = '0; ovalid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          neg_nxt = f_r[31];
          dreq.start = 1'b1;
          dreq.dividend = f_r[31] ? f_r : (f_r << 1);
          dreq.divisor = e_r;
          state_nxt = S_PDIV;
        end
      end
      S_PDIV: begin
        if (drsp.done) begin
          a_nxt = neg_r ? (drsp.quotient << 1) : drsp.quotient;
          state_nxt = S_PQ;
        end
      end
      // a = p
      S_PQ: begin
        ma = asr(a_r, 5'd8); mb = asr(a_r, 5'd8); b_nxt = mp;
        state_nxt = S_P10;
      end
      S_P10: begin
        ma = b_r; mb = KP1; b_nxt = asr(mp, 5'd16);
        state_nxt = S_P11;
      end
      S_P11: begin
        ma = KP2; mb = a_r; c_nxt = asr(mp, 5'd16);
        state_nxt = S_P12;
      end
      S_P12: begin
        ostat_nxt = 1'b0;
        omeas_nxt = a_r + asr(b_r + c_r + KP3, 5'd4);
        ovalid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovalid_r <= 1'b0;
      b5_r <= '0;
      mode_r <= 2'd3;
      ga_r <= '0;
      gb_r <= '0;
      gc_r <= '0;
    end else begin
      state_r <= state_nxt;
      ovalid_r <= ovalid_nxt;
      b5_r <= b5_nxt;
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_MODE: mode_r <= cfg_data[1:0];
          REG_GRP_A: ga_r <= cfg_data;
          REG_GRP_B: gb_r <= cfg_data;
          REG_GRP_C: gc_r <= cfg_data[31:0];
          default: ;
        endcase
      end
    end
    if (in_ch.valid && in_ch.ready) begin
      op_r <= in_ch.operation;
      raw_r <= in_ch.raw_sample;
    end
    a_r <= a_nxt; b_r <= b_nxt; c_r <= c_nxt; d_r <= d_nxt; e_r <= e_nxt; f_r <= f_nxt;
    neg_r <= neg_nxt;
    ostat_r <= ostat_nxt;
    omeas_r <= omeas_nxt;
  end

  `BPC_ASSERT_IMP(a_ready_idle, in_ch.ready, state_r == S_IDLE)
  `BPC_ASSERT_NXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid)
  `BPC_ASSERT_IMP(a_div_wait, drsp.busy, state_r == S_TDIV || state_r == S_PDIV)
endmodule

>>> bench/tb_barometric_pressure_compensation.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_barometric_pressure_compensation
// random and directed temperature and pressure items over several calibrations
// in-order check of each output item against a 32-bit wrapping predictor
// ----------------------------------------------------------------------------
module tb_barometric_pressure_compensation import bpc_pkg::*;;

  typedef struct {
    logic        operation;
    logic [23:0] raw_sample;
  } sample_t;

  typedef struct {
    logic        kind;
    logic [31:0] measurement;
    logic        status;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_MODE;
  logic [63:0] cfg_data = '0;

  bpc_in_if  in_ch ();
  bpc_out_if out_ch ();

  barometric_pressure_compensation i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  sample_t  pending_samples[$];
  reading_t expected_readings[$];
  int       error_count = 0;
  bit       steady = 1'b0;

  // predictor copy of registers and stored b5 term
  logic [1:0]  osr_mode = 2'd3;
  logic [63:0] grp_a = '0;
  logic [63:0] grp_b = '0;
  logic [31:0] grp_c = '0;
  logic [31:0] stored_b5 = '0;

  always #2 clk = ~clk;

  function automatic logic [31:0] shr_arith(input logic [31:0] v, input int s);
    return $signed(v) >>> s;
  endfunction

  function automatic logic [31:0] ext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic reading_t compensate_sample(input sample_t smp);
    reading_t    r;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] ut, up, x1, x2, x3, den, b6, sq, b3, b4, b7, p, t;
    longint      num, q;
    ac1 = ext16(grp_a[63:48]);
    ac2 = ext16(grp_a[47:32]);
    ac3 = ext16(grp_a[31:16]);
    ac4 = {16'd0, grp_a[15:0]};
    ac5 = {16'd0, grp_b[63:48]};
    ac6 = {16'd0, grp_b[47:32]};
    b1  = ext16(grp_b[31:16]);
    b2  = ext16(grp_b[15:0]);
    mc  = ext16(grp_c[31:16]);
    md  = ext16(grp_c[15:0]);
    r.kind = smp.operation;
    r.measurement = '0;
    r.status = 1'b0;
    if (smp.operation == 1'b0) begin
      ut = {16'd0, smp.raw_sample[15:0]};
      t = ut - ac6;
      t = t * ac5;
      x1 = shr_arith(t, 15);
      den = x1 + md;
      if (den == 0) begin
        r.status = 1'b1;
      end else begin
        num = longint'($signed(mc)) * 2048;
        q = num / longint'($signed(den));
        stored_b5 = x1 + q[31:0];
        r.measurement = shr_arith(stored_b5 + 32'd8, 4);
      end
    end else begin
      up = {8'd0, smp.raw_sample} >> (8 - osr_mode);
      b6 = stored_b5 - TempOffset;
      t = b6 * b6;
      sq = shr_arith(t, 12);
      t = b2 * sq;
      x1 = shr_arith(t, 11);
      t = ac2 * b6;
      x2 = shr_arith(t, 11);
      x3 = x1 + x2;
      t = ac1 * 32'd4;
      t = (t + x3) << osr_mode;
      b3 = shr_arith(t + 32'd2, 2);
      t = ac3 * b6;
      x1 = shr_arith(t, 13);
      t = b1 * sq;
      x2 = shr_arith(t, 16);
      x3 = shr_arith(x1 + x2 + 32'd2, 2);
      t = ac4 * (x3 + KHalf);
      b4 = t >> 15;
      t = up - b3;
      b7 = t * (KB7 >> osr_mode);
      if (b4 == 0) begin
        r.status = 1'b1;
      end else begin
        if (b7 < 32'h8000_0000) p = (b7 << 1) / b4;
        else p = (b7 / b4) << 1;
        t = shr_arith(p, 8);
        x1 = t * t;
        t = x1 * KP1;
        x1 = shr_arith(t, 16);
        t = KP2 * p;
        x2 = shr_arith(t, 16);
        r.measurement = p + shr_arith(x1 + x2 + KP3, 4);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    error_count++;
  endtask

  // driver
  always @(posedge clk) begin
    sample_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.operation <= 1'b0;
      in_ch.raw_sample <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        nxt.operation = in_ch.operation;
        nxt.raw_sample = in_ch.raw_sample;
        expected_readings.push_back(compensate_sample(nxt));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_samples.size() > 0 && (steady || $urandom_range(99) >= 24)) begin
          nxt = pending_samples.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.operation <= nxt.operation;
          in_ch.raw_sample <= nxt.raw_sample;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    reading_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("unexpected item", out_ch.measurement, 32'd0);
        end else begin
          want = expected_readings.pop_front();
          if (out_ch.kind !== want.kind)
            report_mismatch("kind", 32'(out_ch.kind), 32'(want.kind));
          if (out_ch.measurement !== want.measurement)
            report_mismatch("measurement", out_ch.measurement, want.measurement);
          if (out_ch.status !== want.status)
            report_mismatch("status", 32'(out_ch.status), 32'(want.status));
        end
      end
      out_ch.ready <= steady || ($urandom_range(99) >= 24);
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_MODE:  osr_mode = value[1:0];
      REG_GRP_A: grp_a = value;
      REG_GRP_B: grp_b = value;
      REG_GRP_C: grp_c = value[31:0];
      default: ;
    endcase
  endtask

  task automatic load_calibration(input logic [1:0] mode, input logic [63:0] a,
                                  input logic [63:0] b, input logic [31:0] c);
    write_reg(REG_MODE, {62'd0, mode});
    write_reg(REG_GRP_A, a);
    write_reg(REG_GRP_B, b);
    write_reg(REG_GRP_C, {32'd0, c});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_sample(input logic op, input logic [23:0] raw);
    sample_t s;
    s.operation = op;
    s.raw_sample = raw;
    pending_samples.push_back(s);
  endtask

  // checked at the falling edge so that all updates of the rising edge have settled
  task automatic drain;
    do @(negedge clk);
    while (pending_samples.size() != 0 || expected_readings.size() != 0 || in_ch.valid);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_raw(input logic op);
    if ($urandom_range(3) == 0) return 24'($urandom);
    if (op == 1'b0) return 24'($urandom_range(20000, 36000));
    return 24'($urandom_range(20000, 50000) << 8) | 24'($urandom_range(255));
  endfunction

  localparam logic [63:0] TypA = {16'd408, 16'hFFB8, 16'hC7D1, 16'd32741};
  localparam logic [63:0] TypB = {16'd32757, 16'd23153, 16'd6190, 16'd4};
  localparam logic [31:0] TypC = {16'hDDF9, 16'd2868};

  initial begin
    logic [63:0] a, b;
    logic [31:0] c;
    logic        op;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset calibration: pressure before temperature, zero divisors
    queue_sample(1'b1, 24'h5D_2300);
    queue_sample(1'b0, 24'h00_6CFA);
    drain();

    load_calibration(2'd0, TypA, TypB, TypC);
    queue_sample(1'b1, 24'h5D_2300);
    queue_sample(1'b0, 24'h00_6CFA);
    queue_sample(1'b0, 24'hFF_6CFA);
    queue_sample(1'b1, 24'h5D_2300);
    queue_sample(1'b0, 24'h00_0000);
    queue_sample(1'b1, 24'h00_0000);
    queue_sample(1'b0, 24'hFF_FFFF);
    queue_sample(1'b1, 24'hFF_FFFF);
    drain();

    load_calibration(2'd3, TypA, TypB, TypC);
    queue_sample(1'b0, 24'h00_6CFA);
    queue_sample(1'b1, 24'h5D_23AB);
    queue_sample(1'b1, 24'hFF_FFFF);
    drain();

    // ac4 zero gives a zero pressure divisor
    load_calibration(2'd1, {TypA[63:16], 16'd0}, TypB, TypC);
    queue_sample(1'b0, 24'h00_6CFA);
    queue_sample(1'b1, 24'h5D_2300);
    drain();

    load_calibration(2'd2, {4{16'h8000}}, {4{16'hFFFF}}, {2{16'h7FFF}});
    queue_sample(1'b0, 24'h00_FFFF);
    queue_sample(1'b1, 24'h80_0000);
    queue_sample(1'b0, 24'h00_0000);
    queue_sample(1'b1, 24'hFF_FFFF);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      steady = (ph == 4);
      if (ph % 3 == 2) begin
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = $urandom;
      end else begin
        a = TypA ^ 64'($urandom_range(255));
        b = TypB ^ {16'($urandom_range(255)), 48'd0};
        c = TypC ^ 32'($urandom_range(63));
      end
      load_calibration(2'($urandom_range(3)), a, b, c);
      for (int n = 0; n < 76; n++) begin
        if (n % 4 == 0) op = 1'b0;
        else op = ($urandom_range(5) != 0);
        queue_sample(op, rand_raw(op));
      end
      drain();
    end
    steady = 1'b0;

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end
endmodule
